FILE: rtl/rrsd_pkg.sv
package rrsd_pkg;

  localparam int ROW_PITCH         = 512;
  localparam int ROWS_PER_PAGE     = 16;
  localparam int MAX_CODES_PER_ROW = 50;
  localparam int LEFT_MARGIN       = 5;

  localparam int RIP_W    = (ROWS_PER_PAGE > 1) ? $clog2(ROWS_PER_PAGE) : 1;
  localparam int CODE_W   = 8;
  localparam int RUN_W    = 7;
  localparam int PAGE_W   = 8;
  localparam int OFFS_W   = 13;
  localparam int XPOS_W   = 9;
  localparam int CODES_W  = 6;
  localparam int WSUM_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PICTURE_VALID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PICTURE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PICTURE_HEIGHT = 2'd2;

  typedef struct packed {
    logic                picture_valid;
    logic [7:0]          picture_width;
    logic [7:0]          picture_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]          rows_left;
    logic [RIP_W-1:0]    row_in_page;
    logic [PAGE_W-1:0]   page_number;
    logic [XPOS_W-1:0]   x_position;
    logic [CODES_W-1:0]  codes_in_row;
    logic [WSUM_W-1:0]   width_sum;
    logic                active;
  } state_t;

  typedef struct packed {
    logic                paint;
    logic [PAGE_W-1:0]   page;
    logic [OFFS_W-1:0]   start_offset;
    logic [RUN_W-1:0]    run_length;
    logic                row_end;
    logic                picture_end;
    logic                ignored;
  } result_t;

endpackage

FILE: rtl/rrsd_step.sv
module rrsd_step (
  input  rrsd_pkg::cfg_t                 cfg,
  input  rrsd_pkg::state_t               cur,
  input  logic [rrsd_pkg::CODE_W-1:0]    code_byte,
  input  logic                           first_byte,
  output rrsd_pkg::state_t               nxt,
  output rrsd_pkg::result_t              res
);

  always_comb begin
    rrsd_pkg::state_t             st;
    logic [rrsd_pkg::RUN_W-1:0]   run;
    logic [rrsd_pkg::WSUM_W-1:0]  wsum_n;
    logic [rrsd_pkg::CODES_W-1:0] codes_n;
    logic [rrsd_pkg::RIP_W:0]     rip_inc;
    logic                         end_row;

    st = cur;
    if (first_byte) begin
      st.rows_left    = cfg.picture_height;
      st.row_in_page  = '0;
      st.page_number  = rrsd_pkg::PAGE_W'(1);
      st.x_position   = '0;
      st.codes_in_row = '0;
      st.width_sum    = '0;
      st.active       = (cfg.picture_height != 8'd0);
    end

    nxt     = st;
    res     = '0;
    run     = code_byte[rrsd_pkg::RUN_W-1:0];
    wsum_n  = rrsd_pkg::WSUM_W'(st.width_sum + {6'd0, run});
    codes_n = rrsd_pkg::CODES_W'(st.codes_in_row + 6'd1);
    rip_inc = {1'b0, st.row_in_page} + (rrsd_pkg::RIP_W+1)'(1);
    end_row = 1'b0;

    if (!cfg.picture_valid || !st.active) begin
      res.ignored = 1'b1;
    end else begin
      res.page         = st.page_number;
      res.start_offset = rrsd_pkg::OFFS_W'(int'(st.row_in_page) * rrsd_pkg::ROW_PITCH
                         + rrsd_pkg::LEFT_MARGIN + int'(st.x_position));
      if (code_byte == 8'h00) begin
        end_row = 1'b1;
      end else begin
        res.paint        = code_byte[7];
        res.run_length   = run;
        nxt.x_position   = rrsd_pkg::XPOS_W'(st.x_position + {2'd0, run});
        nxt.width_sum    = wsum_n;
        nxt.codes_in_row = codes_n;
        if (wsum_n >= {5'd0, cfg.picture_width} ||
            codes_n >= rrsd_pkg::CODES_W'(rrsd_pkg::MAX_CODES_PER_ROW)) begin
          end_row = 1'b1;
        end
      end

      if (end_row) begin
        nxt.x_position   = '0;
        nxt.width_sum    = '0;
        nxt.codes_in_row = '0;
        if (int'(rip_inc) >= rrsd_pkg::ROWS_PER_PAGE) begin
          nxt.row_in_page = '0;
          nxt.page_number = st.page_number + rrsd_pkg::PAGE_W'(1);
        end else begin
          nxt.row_in_page = rip_inc[rrsd_pkg::RIP_W-1:0];
        end
        nxt.rows_left = st.rows_left - 8'd1;
        if (nxt.rows_left == 8'd0) begin
          nxt.active      = 1'b0;
          res.picture_end = 1'b1;
        end
      end
      res.row_end = end_row;
    end
  end

endmodule

FILE: rtl/rle_row_span_decoder.sv
// Run-length row span decoder: each request carries one coded byte of a one-bit picture
// and yields exactly one span command (page, byte offset, length, and paint, row end,
// picture end and ignored flags). One request is taken per clock while in_stall is low;
// a byte passes an input and a result register before its span is on the result ports.
// Picture size and the valid flag must be written through the configuration port only
// while no request is in flight; the block itself does not enforce this.
module rle_row_span_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rrsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrsd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rrsd_pkg::CODE_W-1:0]        in_code_byte,
  input  logic                               in_first_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_paint,
  output logic [rrsd_pkg::PAGE_W-1:0]        out_page,
  output logic [rrsd_pkg::OFFS_W-1:0]        out_start_offset,
  output logic [rrsd_pkg::RUN_W-1:0]         out_run_length,
  output logic                               out_row_end,
  output logic                               out_picture_end,
  output logic                               out_ignored
);

  rrsd_pkg::cfg_t    cfg_r;
  rrsd_pkg::state_t  state_r;
  rrsd_pkg::state_t  state_nxt;
  rrsd_pkg::result_t res_nxt;
  rrsd_pkg::result_t res_r;

  logic                         in_valid_r;
  logic [rrsd_pkg::CODE_W-1:0]  code_r;
  logic                         first_r;
  logic                         out_valid_r;
  logic                         advance;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  rrsd_step u_step (
    .cfg        (cfg_r),
    .cur        (state_r),
    .code_byte  (code_r),
    .first_byte (first_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r                 <= '0;
      state_r               <= '{rows_left: '0, row_in_page: '0,
                                 page_number: rrsd_pkg::PAGE_W'(1), x_position: '0,
                                 codes_in_row: '0, width_sum: '0, active: 1'b0};
      in_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rrsd_pkg::CFG_PICTURE_VALID:  cfg_r.picture_valid  <= cfg_wdata[0];
          rrsd_pkg::CFG_PICTURE_WIDTH:  cfg_r.picture_width  <= cfg_wdata;
          rrsd_pkg::CFG_PICTURE_HEIGHT: cfg_r.picture_height <= cfg_wdata;
          default: ;
        endcase
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      code_r  <= in_code_byte;
      first_r <= in_first_byte;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_paint        = res_r.paint;
  assign out_page         = res_r.page;
  assign out_start_offset = res_r.start_offset;
  assign out_run_length   = res_r.run_length;
  assign out_row_end      = res_r.row_end;
  assign out_picture_end  = res_r.picture_end;
  assign out_ignored      = res_r.ignored;

  a_ignored_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.ignored |->
      res_r.run_length == '0 && !res_r.row_end && !res_r.paint && !res_r.picture_end)
    else $error("ignored span carries data");

  a_pic_end_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.picture_end |-> res_r.row_end)
    else $error("picture end without row end");

  a_pic_end_deactivates: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.picture_end |=> !state_r.active)
    else $error("picture still active after its last row");

  a_row_in_page_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(state_r.row_in_page) < rrsd_pkg::ROWS_PER_PAGE)
    else $error("row in page out of range");

  a_codes_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(state_r.codes_in_row) < rrsd_pkg::MAX_CODES_PER_ROW)
    else $error("code count out of range");

endmodule

FILE: test/rrsd_span_checker.sv
module rrsd_span_checker
  import rrsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [CODE_W-1:0]     in_code_byte,
  input  logic                  in_first_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_paint,
  input  logic [PAGE_W-1:0]     out_page,
  input  logic [OFFS_W-1:0]     out_start_offset,
  input  logic [RUN_W-1:0]      out_run_length,
  input  logic                  out_row_end,
  input  logic                  out_picture_end,
  input  logic                  out_ignored,
  output int                    span_errors,
  output int                    spans_owed
);

  cfg_t               picture_cfg;
  logic [7:0]         rows_to_go;
  logic [RIP_W-1:0]   page_row;
  logic [PAGE_W-1:0]  page_num;
  logic [XPOS_W-1:0]  x_pos;
  logic [CODES_W-1:0] row_codes;
  logic [WSUM_W-1:0]  row_pixels;
  logic               decoding;
  result_t            expected_spans[$];
  int                 error_total = 0;

  // Works out the span command for one request and advances the row and page position.
  function automatic result_t predict_span(input logic [CODE_W-1:0] code, input logic first);
    result_t    span;
    logic       row_done;
    logic [6:0] len;
    span = '0;
    row_done = 1'b0;
    if (first) begin
      rows_to_go = picture_cfg.picture_height;
      page_row = '0;
      page_num = 8'd1;
      x_pos = '0;
      row_codes = '0;
      row_pixels = '0;
      decoding = (picture_cfg.picture_height != 8'd0);
    end
    if (!picture_cfg.picture_valid || !decoding) begin
      span.ignored = 1'b1;
      return span;
    end
    span.page = page_num;
    span.start_offset = OFFS_W'(page_row * ROW_PITCH + LEFT_MARGIN + x_pos);
    if (code == 8'h00) begin
      row_done = 1'b1;
    end else begin
      len = code[6:0];
      span.paint = code[7];
      span.run_length = len;
      x_pos = x_pos + len;
      row_pixels = row_pixels + len;
      row_codes = row_codes + 1'b1;
      if (row_pixels >= picture_cfg.picture_width || row_codes >= MAX_CODES_PER_ROW) begin
        row_done = 1'b1;
      end
    end
    if (row_done) begin
      x_pos = '0;
      row_pixels = '0;
      row_codes = '0;
      if (page_row == RIP_W'(ROWS_PER_PAGE - 1)) begin
        page_row = '0;
        page_num = page_num + 1'b1;
      end else begin
        page_row = page_row + 1'b1;
      end
      rows_to_go = rows_to_go - 1'b1;
      if (rows_to_go == 8'd0) begin
        decoding = 1'b0;
        span.picture_end = 1'b1;
      end
    end
    span.row_end = row_done;
    return span;
  endfunction

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      picture_cfg = '0;
      rows_to_go = '0;
      page_row = '0;
      page_num = 8'd1;
      x_pos = '0;
      row_codes = '0;
      row_pixels = '0;
      decoding = 1'b0;
      expected_spans.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PICTURE_VALID:  picture_cfg.picture_valid = cfg_wdata[0];
          CFG_PICTURE_WIDTH:  picture_cfg.picture_width = cfg_wdata;
          CFG_PICTURE_HEIGHT: picture_cfg.picture_height = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen = {out_paint, out_page, out_start_offset, out_run_length,
                out_row_end, out_picture_end, out_ignored};
        if (expected_spans.size() == 0) begin
          if (error_total < 10) begin
            $display("unexpected span: page %0d offset %0d run %0d", seen.page,
                     seen.start_offset, seen.run_length);
          end
          error_total++;
        end else begin
          want = expected_spans.pop_front();
          if (seen.paint !== want.paint || seen.page !== want.page ||
              seen.start_offset !== want.start_offset ||
              seen.run_length !== want.run_length || seen.row_end !== want.row_end ||
              seen.picture_end !== want.picture_end || seen.ignored !== want.ignored) begin
            if (error_total < 10) begin
              $display("span mismatch: expected paint %0d page %0d offset %0d run %0d",
                       want.paint, want.page, want.start_offset, want.run_length,
                       " row_end %0d picture_end %0d ignored %0d",
                       want.row_end, want.picture_end, want.ignored);
              $display("               got      paint %0d page %0d offset %0d run %0d",
                       seen.paint, seen.page, seen.start_offset, seen.run_length,
                       " row_end %0d picture_end %0d ignored %0d",
                       seen.row_end, seen.picture_end, seen.ignored);
            end
            error_total++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_spans.push_back(predict_span(in_code_byte, in_first_byte));
      end
    end
    span_errors <= error_total;
    spans_owed <= expected_spans.size();
  end

endmodule

FILE: test/tb_top.sv
module tb_top;
  import rrsd_pkg::*;

  localparam int DUT_LATENCY    = 2;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [CODE_W-1:0]     in_code_byte;
  logic                  in_first_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_paint;
  logic [PAGE_W-1:0]     out_page;
  logic [OFFS_W-1:0]     out_start_offset;
  logic [RUN_W-1:0]      out_run_length;
  logic                  out_row_end;
  logic                  out_picture_end;
  logic                  out_ignored;

  int         span_errors;
  int         spans_owed;
  int         send_pct = 0;
  int         recv_pct = 0;
  int         items_left = 0;
  int         quiet_cycles = 0;
  logic [7:0] cur_width = 8'd0;
  logic [7:0] cur_height = 8'd0;

  rle_row_span_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_code_byte(in_code_byte), .in_first_byte(in_first_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_paint(out_paint), .out_page(out_page), .out_start_offset(out_start_offset),
    .out_run_length(out_run_length), .out_row_end(out_row_end),
    .out_picture_end(out_picture_end), .out_ignored(out_ignored)
  );

  rrsd_span_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_code_byte(in_code_byte), .in_first_byte(in_first_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_paint(out_paint), .out_page(out_page), .out_start_offset(out_start_offset),
    .out_run_length(out_run_length), .out_row_end(out_row_end),
    .out_picture_end(out_picture_end), .out_ignored(out_ignored),
    .span_errors(span_errors), .spans_owed(spans_owed)
  );

  initial clk = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_code(input logic [7:0] code, input logic first);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_byte <= code;
    in_first_byte <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_left--;
  endtask

  // Waits until every request has its span back, so the registers can be rewritten.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (spans_owed != 0) @(posedge clk);
    repeat (DUT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic valid, input logic [7:0] width,
                           input logic [7:0] height);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PICTURE_VALID;
    cfg_wdata <= {7'($urandom), valid};
    @(posedge clk);
    cfg_index <= CFG_PICTURE_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_index <= CFG_PICTURE_HEIGHT;
    cfg_wdata <= height;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_width = width;
    cur_height = height;
  endtask

  // Style 0 is an empty row, 1 random runs, 2 medium runs with an occasional early
  // terminator, 3 tiny runs that tend to hit the per-row code limit.
  task automatic send_row(input int style, input logic first);
    int         pixels;
    int         codes;
    logic [7:0] code;
    logic       done;
    pixels = 0;
    codes = 0;
    done = 1'b0;
    if (style == 0) begin
      send_code(8'h00, first);
      return;
    end
    while (!done && items_left > 0) begin
      case (style)
        1: code = 8'($urandom);
        2: code = {1'($urandom), 7'($urandom_range(1, 60))};
        default: code = {1'($urandom), 7'($urandom_range(0, 2))};
      endcase
      if (style == 3 && code == 8'h00) code = 8'h80;
      send_code(code, first);
      first = 1'b0;
      codes++;
      pixels += code[6:0];
      done = code == 8'h00 || pixels >= cur_width || codes >= MAX_CODES_PER_ROW;
      if (!done && style == 2 && $urandom_range(3) == 0) begin
        send_code(8'h00, 1'b0);
        done = 1'b1;
      end
    end
  endtask

  task automatic send_picture();
    int   rows;
    int   r;
    int   pick;
    logic first;
    rows = (cur_height == 8'd0) ? 1 : cur_height;
    first = 1'b1;
    for (r = 0; r < rows && items_left > 0; r++) begin
      if ($urandom_range(39) == 0) break;
      pick = $urandom_range(9);
      send_row(pick == 0 ? 0 : pick < 5 ? 1 : pick < 8 ? 2 : 3, first);
      first = 1'b0;
    end
    if ($urandom_range(2) == 0) send_code(8'($urandom), 1'b0);
  endtask

  initial begin
    int         blk;
    logic [7:0] w;
    logic [7:0] h;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_code_byte <= '0;
    in_first_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pct = 16;
    recv_pct = 71;
    write_cfg(1'b1, 8'd255, 8'd3);
    send_code(8'h85, 1'b0);
    send_code(8'h85, 1'b1);
    send_code(8'h7F, 1'b0);
    send_code(8'h80, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'h01, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'hAA, 1'b0);
    send_code(8'h00, 1'b1);
    send_code(8'h55, 1'b0);
    send_code(8'h7F, 1'b0);
    send_code(8'h2B, 1'b0);
    settle();
    write_cfg(1'b1, 8'd0, 8'd2);
    send_code(8'h03, 1'b1);
    send_code(8'h80, 1'b0);
    settle();
    // A first byte restarts the picture even while it is marked invalid.
    write_cfg(1'b0, 8'd100, 8'd2);
    send_code(8'h81, 1'b1);
    send_code(8'h02, 1'b0);
    settle();
    write_cfg(1'b1, 8'd100, 8'd2);
    send_code(8'h10, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'h00, 1'b0);
    settle();
    write_cfg(1'b1, 8'd40, 8'd0);
    send_code(8'h44, 1'b1);

    for (blk = 0; blk < 12; blk++) begin
      if (blk == 4) begin
        send_pct = 71;
        recv_pct = 16;
      end
      if (blk == 8) begin
        send_pct = 0;
        recv_pct = 0;
      end
      settle();
      case (blk)
        0: write_cfg(1'b1, 8'd255, 8'd255);
        1: write_cfg(1'b1, 8'd0, 8'd3);
        2: write_cfg(1'b0, 8'($urandom), 8'($urandom_range(1, 6)));
        3: write_cfg(1'b1, 8'd255, 8'd1);
        default: begin
          w = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                       : 8'($urandom_range(1, 255));
          h = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
          write_cfg($urandom_range(7) != 0, w, h);
        end
      endcase
      items_left = 150;
      if ($urandom_range(1) == 0) send_row(1, 1'b0);
      while (items_left > 0) begin
        if ($urandom_range(11) == 0) send_code(8'($urandom), $urandom_range(7) == 0);
        else send_picture();
      end
    end

    settle();
    repeat (DUT_LATENCY + 4) @(posedge clk);
    if (span_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rrsd_pkg.sv
rtl/rrsd_step.sv
rtl/rle_row_span_decoder.sv
test/rrsd_span_checker.sv
test/tb_top.sv
